// ----- rtl/core/piezo_hit_detector_core_defines.svh -----
// Assertion macros used by the detector core RTL.
`ifndef PIEZO_HIT_DETECTOR_CORE_DEFINES_SVH
`define PIEZO_HIT_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PHD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PHD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/phd_pkg.sv -----
package phd_pkg;

  localparam int LEVEL_W    = 26;
  localparam int TIME_W     = 63;
  localparam int VEL_W      = 7;
  localparam int COEF_W     = 15;
  localparam int REG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 24;
  localparam int OUT_W      = ((TIME_W + VEL_W + 7) / 8) * 8;

  localparam logic [COEF_W-1:0] RST_DC_COEFFICIENT    = 15'd32440;
  localparam logic [REG_W-1:0]  RST_HIT_THRESHOLD     = 16'd66;
  localparam logic [REG_W-1:0]  RST_PEAK_WINDOW       = 16'd176;
  localparam logic [REG_W-1:0]  RST_REFRACTORY_LENGTH = 16'd551;
  localparam logic [REG_W-1:0]  RST_VELOCITY_GAIN     = 16'd1536;
  localparam logic [REG_W-1:0]  RST_BASELINE_RATE     = 16'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DC_COEFFICIENT    = 3'd0,
    REG_HIT_THRESHOLD     = 3'd1,
    REG_PEAK_WINDOW       = 3'd2,
    REG_REFRACTORY_LENGTH = 3'd3,
    REG_VELOCITY_GAIN     = 3'd4,
    REG_BASELINE_RATE     = 3'd5
  } phd_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0] dc_coefficient;
    logic [REG_W-1:0]  hit_threshold;
    logic [REG_W-1:0]  peak_window;
    logic [REG_W-1:0]  refractory_length;
    logic [REG_W-1:0]  velocity_gain;
    logic [REG_W-1:0]  baseline_rate;
  } phd_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  frame_time;
    logic [LEVEL_W-1:0] level;
  } phd_word_t;

endpackage

// ----- rtl/core/piezo_hit_detector_core.sv -----
// Channel  Direction  Handshake              Word
// in_      slave      in_tvalid/in_tready    tdata: sample, frame_time
// out_     master     out_tvalid/out_tready  tdata: hit_time, velocity
// cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One sample per cycle while in_tready is high; a hit passes s3_r, then out_time_r.
// Each cycle's cost is the DC-blocker feedback, baseline and velocity-gain multiplies.
// rst_n is synchronous: registers return to defaults, state clears at once.
// Samples without a hit keep flowing while a hit waits at the output;
// in_tready drops only when another hit is due and both hit registers are full.
`include "piezo_hit_detector_core_defines.svh"

module piezo_hit_detector_core
  import phd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [SAMPLE_BITS-1:0] sample, [SAMPLE_BITS+62:SAMPLE_BITS] frame_time, zero pad
  input  logic [((SAMPLE_BITS+TIME_W+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [62:0] hit_time, [69:63] velocity, [71:70] zero
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
  localparam logic [CW-1:0] CNT_MAX = CW'((64'd1 << COUNT_BITS) - 64'd1);

  phd_cfg_t cfg_r;

  logic                  lvl_valid;
  logic                  lvl_ready;
  phd_word_t             lvl;
  logic                  hit_valid;
  logic                  hit_ready;
  phd_word_t             hit;
  logic [TIME_W-1:0]     out_time;
  logic [VEL_W-1:0]      out_vel;

  logic [LEVEL_W-1:0]    floor_r, floor_nxt;
  logic                  tracking_r, tracking_nxt;
  logic [LEVEL_W-1:0]    peak_r, peak_nxt;
  logic [COUNT_BITS-1:0] wcount_r, wcount_nxt;
  logic [COUNT_BITS-1:0] lock_r, lock_nxt;

  logic                  s2_fire;
  logic                  hit_n;
  logic                  free;
  logic signed [26:0]    diff;
  logic signed [43:0]    base_prod;
  logic signed [43:0]    base_bias;
  logic signed [27:0]    floor_sum;
  logic [LEVEL_W-1:0]    level;
  logic [THR_W-1:0]      thr;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CW-1:0]         win_ext;
  logic [CW-1:0]         win_c;
  logic [CW-1:0]         ref_ext;
  logic [CW-1:0]         ref_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dc_coefficient    <= RST_DC_COEFFICIENT;
      cfg_r.hit_threshold     <= RST_HIT_THRESHOLD;
      cfg_r.peak_window       <= RST_PEAK_WINDOW;
      cfg_r.refractory_length <= RST_REFRACTORY_LENGTH;
      cfg_r.velocity_gain     <= RST_VELOCITY_GAIN;
      cfg_r.baseline_rate     <= RST_BASELINE_RATE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DC_COEFFICIENT:    cfg_r.dc_coefficient    <= cfg_data[COEF_W-1:0];
        REG_HIT_THRESHOLD:     cfg_r.hit_threshold     <= cfg_data;
        REG_PEAK_WINDOW:       cfg_r.peak_window       <= cfg_data;
        REG_REFRACTORY_LENGTH: cfg_r.refractory_length <= cfg_data;
        REG_VELOCITY_GAIN:     cfg_r.velocity_gain     <= cfg_data;
        REG_BASELINE_RATE:     cfg_r.baseline_rate     <= cfg_data;
        default: ;
      endcase
    end
  end

  phd_dc_filter #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_sample(in_tdata[SAMPLE_BITS-1:0]),
    .in_time  (in_tdata[SAMPLE_BITS+TIME_W-1:SAMPLE_BITS]),
    .lvl_valid(lvl_valid),
    .lvl_ready(lvl_ready),
    .lvl      (lvl)
  );

  always_comb begin
    free      = !tracking_r && (lock_r == '0);
    diff      = $signed({1'b0, lvl.level}) - $signed({1'b0, floor_r});
    base_prod = 44'($signed({1'b0, cfg_r.baseline_rate})) * 44'(diff);
    base_bias = base_prod + 44'sd32768;
    floor_sum = $signed({2'b0, floor_r}) + base_bias[43:16];
    floor_nxt = free ? floor_sum[LEVEL_W-1:0] : floor_r;
    level     = (lvl.level > floor_nxt) ? lvl.level - floor_nxt : '0;
    thr       = {cfg_r.hit_threshold, 8'b0};
    count_inc = (wcount_r == '1) ? wcount_r : wcount_r + 1'b1;
    win_ext   = CW'(cfg_r.peak_window);
    win_c     = (win_ext > CNT_MAX) ? CNT_MAX : win_ext;
    ref_ext   = CW'(cfg_r.refractory_length);
    ref_c     = (ref_ext > CNT_MAX) ? CNT_MAX : ref_ext;
  end

  always_comb begin
    tracking_nxt = tracking_r;
    peak_nxt     = peak_r;
    wcount_nxt   = wcount_r;
    lock_nxt     = lock_r;
    hit_n        = 1'b0;
    priority if (lock_r != '0) begin
      lock_nxt = lock_r - 1'b1;
    end else if (!tracking_r) begin
      if (level >= LEVEL_W'(thr)) begin
        tracking_nxt = 1'b1;
        peak_nxt     = level;
        wcount_nxt   = '0;
      end
    end else begin
      peak_nxt   = (level > peak_r) ? level : peak_r;
      wcount_nxt = count_inc;
      if (CW'(count_inc) >= win_c) begin
        hit_n        = 1'b1;
        tracking_nxt = 1'b0;
        lock_nxt     = ref_c[COUNT_BITS-1:0];
      end
    end
  end

  assign lvl_ready      = !hit_n || hit_ready;
  assign s2_fire        = lvl_valid && lvl_ready;
  assign hit_valid      = lvl_valid && hit_n;
  assign hit.frame_time = lvl.frame_time;
  assign hit.level      = peak_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r    <= '0;
      tracking_r <= 1'b0;
      peak_r     <= '0;
      wcount_r   <= '0;
      lock_r     <= '0;
    end else if (s2_fire) begin
      floor_r    <= floor_nxt;
      tracking_r <= tracking_nxt;
      peak_r     <= peak_nxt;
      wcount_r   <= wcount_nxt;
      lock_r     <= lock_nxt;
    end
  end

  phd_velocity u_velocity (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .hit_valid   (hit_valid),
    .hit_ready   (hit_ready),
    .hit         (hit),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_time    (out_time),
    .out_velocity(out_vel)
  );

  assign out_tdata = {{(OUT_W-TIME_W-VEL_W){1'b0}}, out_vel, out_time};

  `PHD_ASSERT_NOW(a_track_vs_lock, clk, rst_n, tracking_r, lock_r == '0,
    "peak window open during lockout")
  `PHD_ASSERT_NOW(a_hit_from_window, clk, rst_n, hit_valid,
    tracking_r && (lock_r == '0), "hit raised outside an open window")
  `PHD_ASSERT_NEXT(a_floor_hold, clk, rst_n, !s2_fire || tracking_r || (lock_r != '0),
    $stable(floor_r), "baseline moved while busy or stalled")
  `PHD_ASSERT_NEXT(a_hit_lockout, clk, rst_n, hit_valid && lvl_ready,
    !tracking_r, "window still open after a hit")

endmodule

// ----- rtl/core/phd_dc_filter.sv -----
module phd_dc_filter
  import phd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  phd_cfg_t               cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [TIME_W-1:0]      in_time,
  output logic                   lvl_valid,
  input  logic                   lvl_ready,
  output phd_word_t              lvl
);

  localparam int LEVEL_SHIFT = 24 - SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0]    last_sample_r;
  logic signed [LEVEL_W-1:0] last_filt_r;
  logic                      lvl_valid_r;
  phd_word_t                 lvl_r;

  logic [23:0]               x_cur;
  logic [23:0]               x_prev;
  logic signed [41:0]        fb_prod;
  logic signed [41:0]        fb_bias;
  logic signed [26:0]        fb_rnd;
  logic signed [27:0]        y_sum;
  logic signed [LEVEL_W-1:0] y_sat;
  logic signed [26:0]        y_abs;
  logic                      accept;

  always_comb begin
    x_cur   = 24'(in_sample) << LEVEL_SHIFT;
    x_prev  = 24'(last_sample_r) << LEVEL_SHIFT;
    fb_prod = 42'($signed({1'b0, cfg.dc_coefficient})) * 42'(last_filt_r);
    fb_bias = fb_prod + 42'sd16384;
    fb_rnd  = fb_bias[41:15];
    y_sum   = $signed({4'b0, x_cur}) - $signed({4'b0, x_prev}) + 28'(fb_rnd);
    priority if (y_sum > 28'sd33554431) begin
      y_sat = 26'sh1FFFFFF;
    end else if (y_sum < -28'sd33554432) begin
      y_sat = 26'sh2000000;
    end else begin
      y_sat = y_sum[LEVEL_W-1:0];
    end
    y_abs = y_sat[LEVEL_W-1] ? -27'(y_sat) : 27'(y_sat);
  end

  assign in_ready = !lvl_valid_r || lvl_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      last_filt_r   <= '0;
      lvl_valid_r   <= 1'b0;
    end else if (accept) begin
      last_sample_r <= in_sample;
      last_filt_r   <= y_sat;
      lvl_valid_r   <= 1'b1;
    end else if (lvl_ready) begin
      lvl_valid_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lvl_r.frame_time <= in_time;
      lvl_r.level      <= y_abs[LEVEL_W-1:0];
    end
  end

  assign lvl_valid = lvl_valid_r;
  assign lvl       = lvl_r;

endmodule

// ----- rtl/core/phd_velocity.sv -----
module phd_velocity
  import phd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  phd_cfg_t          cfg,
  input  logic              hit_valid,
  output logic              hit_ready,
  input  phd_word_t         hit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TIME_W-1:0] out_time,
  output logic [VEL_W-1:0]  out_velocity
);

  logic              s3_valid_r;
  phd_word_t         s3_r;
  logic              out_valid_r;
  logic [TIME_W-1:0] out_time_r;
  logic [VEL_W-1:0]  out_vel_r;

  logic              advance;
  logic [41:0]       gain_prod;
  logic [32:0]       gain_clip;
  logic [39:0]       scaled;

  always_comb begin
    gain_prod = 42'(s3_r.level) * 42'(cfg.velocity_gain);
    gain_clip = (gain_prod > 42'h1_0000_0000) ? 33'h1_0000_0000 : gain_prod[32:0];
    scaled    = {gain_clip, 7'b0} - 40'(gain_clip) + 40'h80_0000_00;
  end

  assign advance   = !out_valid_r || out_ready;
  assign hit_ready = !s3_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (hit_valid && hit_ready) begin
        s3_valid_r <= 1'b1;
      end else if (advance) begin
        s3_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_valid && hit_ready) begin
      s3_r <= hit;
    end
    if (advance && s3_valid_r) begin
      out_time_r <= s3_r.frame_time;
      out_vel_r  <= scaled[38:32];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_time     = out_time_r;
  assign out_velocity = out_vel_r;

endmodule

// ----- tb/tb_piezo_hit_detector_core.sv -----
module tb_piezo_hit_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import phd_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int IN_W = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
  localparam int LIMIT_CYCLES = 100000;
  localparam int DRAIN_CYCLES = 10;
  localparam int SHOWN_MAX = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint DC_OUT_MAX = 33554431;
  localparam longint DC_OUT_MIN = -33554432;

  typedef struct {
    logic [TIME_W-1:0] hit_time;
    logic [VEL_W-1:0]  velocity;
  } hit_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // sample, frame_time, zero pad
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // hit_time, velocity, zero pad
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hit_t hits_due[$];
  int   fails = 0;
  int   samples_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_len = 0;
  int   hold_left = 0;
  logic hold_start = 1'b0;
  logic [TIME_W-1:0] frame_now = '0;

  phd_cfg_t           cfg_model;
  logic [15:0]        prev_raw = '0;
  longint             prev_dc_out = 0;
  logic [LEVEL_W-1:0] baseline = '0;
  logic               window_open = 1'b0;
  logic [LEVEL_W-1:0] max_level = '0;
  logic [15:0]        window_len = '0;
  logic [15:0]        lockout_left = '0;

  piezo_hit_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DC_COEFFICIENT:    cfg_model.dc_coefficient = d[COEF_W-1:0];
      REG_HIT_THRESHOLD:     cfg_model.hit_threshold = d;
      REG_PEAK_WINDOW:       cfg_model.peak_window = d;
      REG_REFRACTORY_LENGTH: cfg_model.refractory_length = d;
      REG_VELOCITY_GAIN:     cfg_model.velocity_gain = d;
      REG_BASELINE_RATE:     cfg_model.baseline_rate = d;
      default: ;
    endcase
  endfunction

  function automatic void detect_hit(input logic [15:0] raw, input logic [TIME_W-1:0] stamp);
    longint x, xp, fb, y;
    longint unsigned mag, lvl, thr, p;
    hit_t h;
    x = longint'({raw, 8'h00});
    xp = longint'({prev_raw, 8'h00});
    fb = longint'(cfg_model.dc_coefficient) * prev_dc_out;
    y = x - xp + ((fb + 64'sd16384) >>> 15);
    if (y > DC_OUT_MAX) y = DC_OUT_MAX;
    else if (y < DC_OUT_MIN) y = DC_OUT_MIN;
    prev_raw = raw;
    prev_dc_out = y;
    mag = (y < 0) ? -y : y;
    if (!window_open && lockout_left == 0)
      baseline = LEVEL_W'(((64'd65536 - 64'(cfg_model.baseline_rate)) * 64'(baseline)
                           + 64'(cfg_model.baseline_rate) * mag + 64'd32768) >> 16);
    lvl = (mag > 64'(baseline)) ? mag - 64'(baseline) : 64'd0;
    if (lockout_left != 0) begin
      lockout_left--;
      return;
    end
    thr = 64'({cfg_model.hit_threshold, 8'h00});
    if (!window_open) begin
      if (lvl >= thr) begin
        window_open = 1'b1;
        max_level = LEVEL_W'(lvl);
        window_len = '0;
      end
      return;
    end
    if (lvl > 64'(max_level)) max_level = LEVEL_W'(lvl);
    if (window_len != 16'hFFFF) window_len++;
    if (window_len >= cfg_model.peak_window) begin
      p = 64'(max_level) * 64'(cfg_model.velocity_gain);
      if (p > 64'h1_0000_0000) p = 64'h1_0000_0000;
      window_open = 1'b0;
      lockout_left = cfg_model.refractory_length;
      h.hit_time = stamp;
      h.velocity = VEL_W'((p * 127 + 64'h8000_0000) >> 32);
      hits_due.push_back(h);
    end
  endfunction

  function automatic void check_hit(input logic [OUT_W-1:0] word);
    hit_t h;
    if (hits_due.size() == 0) begin
      fails++;
      if (fails <= SHOWN_MAX)
        $display("unexpected hit word: time %h velocity %0d",
                 word[TIME_W-1:0], word[TIME_W +: VEL_W]);
      return;
    end
    h = hits_due.pop_front();
    if (word[TIME_W-1:0] !== h.hit_time || word[TIME_W +: VEL_W] !== h.velocity ||
        word[OUT_W-1:TIME_W+VEL_W] !== '0) begin
      fails++;
      if (fails <= SHOWN_MAX)
        $display("hit mismatch: time exp %h got %h, velocity exp %0d got %0d, pad %b",
                 h.hit_time, word[TIME_W-1:0], h.velocity, word[TIME_W +: VEL_W],
                 word[OUT_W-1:TIME_W+VEL_W]);
    end
  endfunction

  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_n && out_tvalid && out_tready) check_hit(out_tdata);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("piezo_hit_detector_core test failed");
    $finish;
  end

  function automatic logic [TIME_W-1:0] next_frame();
    if ($urandom_range(199) == 0) frame_now = TIME_W'({$urandom, $urandom});
    else frame_now = frame_now + TIME_W'($urandom_range(1, 3));
    return frame_now;
  endfunction

  function automatic logic [15:0] clip16(input int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  task automatic send_sample(input logic [15:0] raw, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({stamp, raw});
    do @(posedge clk); while (!in_tready);
    detect_hit(raw, stamp);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
  endtask

  task automatic set_config(input logic [15:0] dc, input logic [15:0] thr,
                            input logic [15:0] win, input logic [15:0] refr,
                            input logic [15:0] gain, input logic [15:0] rate);
    wait_drained();
    cfg_put(REG_DC_COEFFICIENT, dc);
    cfg_put(REG_HIT_THRESHOLD, thr);
    cfg_put(REG_PEAK_WINDOW, win);
    cfg_put(REG_REFRACTORY_LENGTH, refr);
    cfg_put(REG_VELOCITY_GAIN, gain);
    cfg_put(REG_BASELINE_RATE, rate);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_random_config();
    logic [15:0] thr, win, rate;
    thr = 16'(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, 300));
    win = 16'(($urandom_range(7) == 0) ? $urandom_range(13, 60)
                                       : $urandom_range(0, 12));
    rate = 16'($urandom_range(1) ? $urandom_range(0, 200) : $urandom_range(0, 65535));
    set_config(16'($urandom_range(0, 65535)), thr, win, 16'($urandom_range(0, 30)),
               16'($urandom_range(0, 65535)), rate);
  endtask

  // quiet stretch then a decaying ring; rest is noise or cut-off strikes
  task automatic play_burst();
    int kind, center, amp, ring, a;
    kind = $urandom_range(99);
    center = $urandom_range(0, 65535);
    amp = $urandom_range(200, 40000);
    ring = $urandom_range(2, 20);
    if (kind < 75) begin
      repeat ($urandom_range(5, 30))
        send_sample(clip16(center + $urandom_range(0, 24) - 12), next_frame());
      for (int i = 0; i < ring; i++) begin
        a = amp * (ring - i) / ring;
        send_sample(clip16((i % 2 == 0) ? center + a : center - a), next_frame());
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 10))
        send_sample(16'($urandom_range(0, 65535)), next_frame());
    end else begin
      repeat ($urandom_range(1, 3))
        send_sample(clip16(center + amp - $urandom_range(0, 2 * amp)), next_frame());
      center = $urandom_range(0, 65535);
      repeat ($urandom_range(1, 8))
        send_sample(clip16(center + $urandom_range(0, 24) - 12), next_frame());
    end
  endtask

  task automatic test_directed();
    send_sample(16'h0000, '0);
    send_sample(16'hFFFF, TIME_MAX);
    send_sample(16'h0000, TIME_W'(1));
    send_sample(16'h8000, TIME_W'(2));
    set_config(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, TIME_MAX);
    send_sample(16'h0000, TIME_MAX - 1);
    send_sample(16'hFFFF, TIME_W'(3));
    send_sample(16'h0000, TIME_W'(4));
    send_sample(16'h1234, TIME_W'(5));
    send_sample(16'h1234, TIME_W'(6));
    set_config(16'h0000, 16'hFFFF, 16'h0001, 16'h0001, 16'h0100, 16'h0000);
    send_sample(16'h0000, TIME_W'(7));
    send_sample(16'hFFFF, TIME_W'(8));
    send_sample(16'h0000, TIME_W'(9));
    send_sample(16'hFFFF, TIME_W'(10));
    wait_drained();
    cfg_put(REG_SPARE_LO, 16'hFFFF);
    cfg_put(REG_SPARE_HI, 16'h0000);
    cfg_put(REG_HIT_THRESHOLD, 16'h0010);
    cfg_put(REG_BASELINE_RATE, 16'hFFFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(16'h0000, TIME_W'(11));
    send_sample(16'hFFFF, TIME_W'(12));
    send_sample(16'h7FFF, TIME_W'(13));
    send_sample(16'h0001, TIME_W'(14));
    send_sample(16'hFFFE, TIME_W'(15));
  endtask

  task automatic test_strike_phases();
    int idle_set[4][2];
    int target;
    idle_set = '{'{0, 0}, '{76, 0}, '{0, 76}, '{23, 23}};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      repeat (3) begin
        set_random_config();
        target = samples_sent + 110;
        while (samples_sent < target) play_burst();
      end
    end
  endtask

  task automatic test_backpressure();
    set_config(16'd32440, 16'h0000, 16'h0001, 16'h0000, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (200) send_sample(16'($urandom_range(0, 65535)), next_frame());
    wait_drained();
  endtask

  task automatic test_counter_limits();
    set_config(16'($urandom_range(0, 65535)), 16'h0000, 16'hFFFF, 16'hFFFF,
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) send_sample(16'($urandom_range(0, 65535)), next_frame());
    wait_drained();
  endtask

  initial begin
    cfg_model = '{dc_coefficient: RST_DC_COEFFICIENT, hit_threshold: RST_HIT_THRESHOLD,
                  peak_window: RST_PEAK_WINDOW, refractory_length: RST_REFRACTORY_LENGTH,
                  velocity_gain: RST_VELOCITY_GAIN, baseline_rate: RST_BASELINE_RATE};
    frame_now = TIME_W'({$urandom, $urandom});
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_strike_phases();
    test_backpressure();
    test_counter_limits();
    wait_drained();
    if (fails == 0 && hits_due.size() == 0) begin
      $display("piezo_hit_detector_core test passed");
    end else begin
      $display("piezo_hit_detector_core test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/phd_pkg.sv
rtl/core/phd_dc_filter.sv
rtl/core/phd_velocity.sv
rtl/core/piezo_hit_detector_core.sv
tb/tb_piezo_hit_detector_core.sv
